// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define HCBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define HCBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types, constants and helpers of the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int WORD_BITS    = 64;
  localparam int SYMBOL_COUNT = 256;

  localparam int LEN_W   = $clog2(WORD_BITS + 1);
  localparam int SYM_W   = $clog2(SYMBOL_COUNT);
  localparam int SHIFT_W = $clog2(2 * WORD_BITS + 1);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } hcbp_op_e;

  typedef struct packed {
    hcbp_op_e    operation;
    logic [7:0]  symbol;
    logic [63:0] code_value;
    logic [6:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [63:0] packed_word;
    logic [6:0]  bits_used;
    logic        final_word;
  } out_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic [LEN_W-1:0]     length;
  } entry_t;

  // Control of the packing stage.
  typedef struct packed {
    logic valid;
    logic flush;
  } s1_ctrl_t;

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [WORD_BITS-1:0] one;
    one = {{(WORD_BITS-1){1'b0}}, 1'b1};
    if (n >= LEN_W'(WORD_BITS)) begin
      return '1;
    end
    return (one << n) - one;
  endfunction

endpackage

// ===== src/hcbp_code_table.sv =====
// ----------------------------------------------------------------------------
// hcbp_code_table
// Code table memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module hcbp_code_table (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [hcbp_pkg::SYM_W-1:0] waddr_i,
  input  hcbp_pkg::entry_t         wdata_i,
  input  logic                     re_i,
  input  logic [hcbp_pkg::SYM_W-1:0] raddr_i,
  output hcbp_pkg::entry_t         rdata_o
);

  hcbp_pkg::entry_t mem [hcbp_pkg::SYMBOL_COUNT];
  hcbp_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/hcbp_packer.sv =====
// ----------------------------------------------------------------------------
// hcbp_packer
// Accumulator stage: appends looked-up codes and drives the output register.
// ----------------------------------------------------------------------------
module hcbp_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcbp_pkg::s1_ctrl_t  s1_i,
  input  hcbp_pkg::entry_t    entry_i,
  output logic                go_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hcbp_pkg::out_item_t out_data_o
);

  localparam int W = hcbp_pkg::WORD_BITS;
  localparam int L = hcbp_pkg::LEN_W;
  localparam int S = hcbp_pkg::SHIFT_W;

  logic [W-1:0]        acc_q, acc_d;
  logic [L-1:0]        fill_q, fill_d;
  logic                out_valid_q, out_valid_d;
  hcbp_pkg::out_item_t out_data_q, out_data_d;

  logic [2*W-1:0] code_wide;
  logic [2*W-1:0] shifted;
  logic [2*W-1:0] merged;
  logic [S-1:0]   shamt;
  logic [L:0]     new_fill;
  logic           step;

  assign go_o = !out_valid_q || out_ready_i;
  assign step = s1_i.valid && go_o;

  // The code is placed so that its first bit lands just below the pending
  // bits; the upper half is the word and the lower half the overflow.
  assign code_wide = {{W{1'b0}}, entry_i.value};
  assign shamt     = S'(2 * W) - S'(fill_q) - S'(entry_i.length);
  assign shifted   = code_wide << shamt;
  assign merged    = {acc_q, {W{1'b0}}} | shifted;
  assign new_fill  = (L+1)'(fill_q) + (L+1)'(entry_i.length);

  always_comb begin
    acc_d       = acc_q;
    fill_d      = fill_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (step) begin
      if (s1_i.flush) begin
        acc_d                  = '0;
        fill_d                 = '0;
        out_valid_d            = 1'b1;
        out_data_d.packed_word = 64'(acc_q);
        out_data_d.bits_used   = 7'(fill_q);
        out_data_d.final_word  = 1'b1;
      end else if (entry_i.length != '0) begin
        if (new_fill >= (L+1)'(W)) begin
          acc_d                  = merged[W-1:0];
          fill_d                 = L'(new_fill - (L+1)'(W));
          out_valid_d            = 1'b1;
          out_data_d.packed_word = 64'(merged[2*W-1:W]);
          out_data_d.bits_used   = 7'(W);
          out_data_d.final_word  = 1'b0;
        end else begin
          acc_d  = merged[2*W-1:W];
          fill_d = L'(new_fill);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/huffman_code_bit_packer.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer: Huffman code bit packer with a 256-entry code table.
// An item passes the packing stage and table read registers, then the output register.
// Throughput: one item per cycle while the output register is not held by out_ready.
// Reset clears accumulator, fill count and valid flags; the table is not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_code_bit_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hcbp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hcbp_pkg::out_item_t out_data_o
);

  localparam int L = hcbp_pkg::LEN_W;
  localparam int SYM_W = hcbp_pkg::SYM_W;

  logic               accept;
  logic               in_range;
  logic               we;
  logic               re;
  logic               go;
  logic [L-1:0]       load_len;
  hcbp_pkg::entry_t   wentry;
  hcbp_pkg::entry_t   rentry;
  hcbp_pkg::s1_ctrl_t s1_q, s1_d;

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = {1'b0, in_data_i.symbol} < 9'(hcbp_pkg::SYMBOL_COUNT);
  assign in_ready_o = !s1_q.valid || go;

  // Lengths above the word are clamped and stray value bits cleared on load.
  assign load_len = (in_data_i.code_length > 7'(hcbp_pkg::WORD_BITS)) ?
                    L'(hcbp_pkg::WORD_BITS) : L'(in_data_i.code_length);
  assign wentry.length = load_len;
  assign wentry.value  = in_data_i.code_value[hcbp_pkg::WORD_BITS-1:0] &
                         hcbp_pkg::low_mask(load_len);

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    s1_d = s1_q;
    if (in_ready_o) begin
      s1_d = '0;
    end
    if (accept) begin
      unique case (in_data_i.operation)
        hcbp_pkg::OP_LOAD: begin
          we = in_range;
        end
        hcbp_pkg::OP_ENCODE: begin
          re = in_range;
          s1_d.valid = in_range;
        end
        hcbp_pkg::OP_FLUSH: begin
          s1_d.valid = 1'b1;
          s1_d.flush = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  hcbp_code_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (in_data_i.symbol[SYM_W-1:0]),
    .wdata_i (wentry),
    .re_i    (re),
    .raddr_i (in_data_i.symbol[SYM_W-1:0]),
    .rdata_o (rentry)
  );

  hcbp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_i        (s1_q),
    .entry_i     (rentry),
    .go_o        (go),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `HCBP_ASSERT(a_flush_reaches_stage, clk_i, rst_ni, (accept && in_data_i.operation == hcbp_pkg::OP_FLUSH) |=> s1_q.valid && s1_q.flush, "accepted flush did not enter the packing stage")
  `HCBP_ASSERT(a_stage_holds, clk_i, rst_ni, (s1_q.valid && !in_ready_o) |=> (s1_q.valid && $stable(s1_q.flush)), "stalled packing stage lost its transaction")
  `HCBP_ASSERT(a_flush_emits_final, clk_i, rst_ni, (s1_q.valid && s1_q.flush && go) |=> (out_valid_o && out_data_o.final_word), "flush did not produce a final word")
  `HCBP_ASSERT_ALWAYS(a_full_word_count, clk_i, (out_valid_o && !out_data_o.final_word) |-> (out_data_o.bits_used == 7'(hcbp_pkg::WORD_BITS)), "non-final word is not full")

endmodule

// ===== dv/hcbp_checker.sv =====
// ----------------------------------------------------------------------------
// hcbp_checker
// Watches both channels of the Huffman code bit packer, predicts the packed
// words from the accepted input transactions and compares every output
// transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbp_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  hcbp_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  hcbp_pkg::out_item_t out_data_i,
  output int                  mismatch_count_o,
  output int                  words_pending_o
);

  logic [hcbp_pkg::WORD_BITS-1:0] code_value_tbl [hcbp_pkg::SYMBOL_COUNT];
  logic [6:0]                     code_length_tbl [hcbp_pkg::SYMBOL_COUNT];
  logic [hcbp_pkg::WORD_BITS-1:0] acc_bits = '0;
  int                             fill_bits = 0;
  hcbp_pkg::out_item_t            expected_words [$];

  task automatic pack_item(input hcbp_pkg::in_item_t item);
    int                             len;
    int                             space;
    int                             rest;
    int unsigned                    sym;
    logic [hcbp_pkg::WORD_BITS-1:0] word;
    sym = item.symbol;
    case (item.operation)
      hcbp_pkg::OP_LOAD: begin
        if (sym < hcbp_pkg::SYMBOL_COUNT) begin
          len = (item.code_length > hcbp_pkg::WORD_BITS) ? hcbp_pkg::WORD_BITS :
                item.code_length;
          code_length_tbl[sym] = 7'(len);
          // A shift by the full word width leaves an all-zero mask.
          code_value_tbl[sym] = item.code_value &
                                ({hcbp_pkg::WORD_BITS{1'b1}} >> (hcbp_pkg::WORD_BITS - len));
        end
      end
      hcbp_pkg::OP_ENCODE: begin
        if (sym < hcbp_pkg::SYMBOL_COUNT && code_length_tbl[sym] != 0) begin
          len   = code_length_tbl[sym];
          space = hcbp_pkg::WORD_BITS - fill_bits;
          if (len < space) begin
            acc_bits  = acc_bits | (code_value_tbl[sym] << (space - len));
            fill_bits = fill_bits + len;
          end else begin
            // When the code exactly fills the word, rest is zero and the
            // left shift by the word width empties the accumulator.
            rest      = len - space;
            word      = acc_bits | (code_value_tbl[sym] >> rest);
            acc_bits  = code_value_tbl[sym] << (hcbp_pkg::WORD_BITS - rest);
            fill_bits = rest;
            expected_words.push_back('{packed_word: word,
                                       bits_used: 7'(hcbp_pkg::WORD_BITS),
                                       final_word: 1'b0});
          end
        end
      end
      hcbp_pkg::OP_FLUSH: begin
        expected_words.push_back('{packed_word: acc_bits, bits_used: 7'(fill_bits),
                                   final_word: 1'b1});
        acc_bits  = '0;
        fill_bits = 0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    hcbp_pkg::out_item_t want;
    if (!rst_ni) begin
      acc_bits  = '0;
      fill_bits = 0;
      expected_words.delete();
      words_pending_o = 0;
    end else begin
      // Results pass the packing stage and output registers after their item, so the output side is
      // checked before this edge's input transaction adds a prediction.
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: packed_word %h, bits_used %0d, final_word %0b",
                 out_data_i.packed_word, out_data_i.bits_used, out_data_i.final_word);
          mismatch_count_o++;
        end else begin
          want = expected_words.pop_front();
          if (out_data_i.packed_word !== want.packed_word) begin
            $error("packed_word: expected %h, actual %h", want.packed_word,
                   out_data_i.packed_word);
            mismatch_count_o++;
          end
          if (out_data_i.bits_used !== want.bits_used) begin
            $error("bits_used: expected %0d, actual %0d", want.bits_used,
                   out_data_i.bits_used);
            mismatch_count_o++;
          end
          if (out_data_i.final_word !== want.final_word) begin
            $error("final_word: expected %0b, actual %0b", want.final_word,
                   out_data_i.final_word);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pack_item(in_data_i);
      end
      words_pending_o = expected_words.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives load, encode, flush and unused-opcode transactions into the Huffman code
// bit packer with random idling on both sides, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 1128;
  localparam int         CALM_ITEMS   = 150;
  localparam int         HOLD_CYCLES  = 300;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  hcbp_pkg::in_item_t  in_data   = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_ready = 1'b0;
  hcbp_pkg::out_item_t out_data;
  int                  mismatch_count;
  int                  words_pending;

  bit         calm         = 1'b0;
  bit         hold_pending = 1'b0;
  bit         hold_served  = 1'b0;
  bit         loaded [hcbp_pkg::SYMBOL_COUNT];
  logic [7:0] loaded_syms [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  huffman_code_bit_packer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  hcbp_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatch_count),
    .words_pending_o (words_pending)
  );

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic hcbp_pkg::in_item_t make_item(input logic [1:0] op,
                                                   input logic [7:0] sym,
                                                   input logic [63:0] value,
                                                   input logic [6:0] len);
    hcbp_pkg::in_item_t item;
    item.operation   = hcbp_pkg::hcbp_op_e'(op);
    item.symbol      = sym;
    item.code_value  = value;
    item.code_length = len;
    return item;
  endfunction

  task automatic drive_item(input hcbp_pkg::in_item_t item);
    if (item.operation == hcbp_pkg::OP_LOAD && !loaded[item.symbol]) begin
      loaded[item.symbol] = 1'b1;
      loaded_syms.push_back(item.symbol);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_idle(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (words_pending == 0);
    repeat (4) @(negedge clk);
  endtask

  // Receiver side: random stall bursts, one long hold-off on request.
  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_pending && !hold_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int         pick;
    logic [6:0] len;
    logic [7:0] sym;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    drive_item(make_item(hcbp_pkg::OP_FLUSH, 8'h00, '0, '0));   // flush with nothing pending
    drive_item(make_item(hcbp_pkg::OP_LOAD, 8'h00, '1, 7'd64));
    drive_item(make_item(hcbp_pkg::OP_LOAD, 8'hFF, '1, 7'd1));  // stray value bits
    drive_item(make_item(hcbp_pkg::OP_LOAD, 8'h01, rand_word(), 7'd0)); // zero-length code
    drive_item(make_item(hcbp_pkg::OP_LOAD, 8'h02, 64'hA5C3_0F96_5A3C_F069, 7'd127));
    drive_item(make_item(hcbp_pkg::OP_LOAD, 8'h03, 64'h8000_0000_0000_0001, 7'd65));
    drive_item(make_item(hcbp_pkg::OP_LOAD, 8'h04, rand_word(), 7'd63));
    drive_item(make_item(hcbp_pkg::OP_LOAD, 8'h05, 64'h0000_0000_0000_005B, 7'd7));
    drive_item(make_item(hcbp_pkg::OP_ENCODE, 8'h01, '1, '1));
    drive_item(make_item(hcbp_pkg::OP_ENCODE, 8'hFF, '0, '0));
    drive_item(make_item(hcbp_pkg::OP_ENCODE, 8'h04, '0, '0));  // fills the word exactly
    drive_item(make_item(hcbp_pkg::OP_ENCODE, 8'h05, '0, '0));
    drive_item(make_item(hcbp_pkg::OP_ENCODE, 8'h00, '0, '0));  // spills into the next word
    drive_item(make_item(OP_UNUSED, 8'hFF, '1, '1));
    drive_item(make_item(hcbp_pkg::OP_FLUSH, 8'hFF, '1, '1));
    drive_item(make_item(hcbp_pkg::OP_ENCODE, 8'h02, '0, '0));
    drive_item(make_item(hcbp_pkg::OP_ENCODE, 8'h03, '0, '0));
    drive_item(make_item(hcbp_pkg::OP_FLUSH, 8'h00, '0, '0));
    drive_item(make_item(hcbp_pkg::OP_LOAD, 8'h80, '0, 7'd32));
    drive_item(make_item(hcbp_pkg::OP_ENCODE, 8'h80, '0, '0));
    drive_item(make_item(hcbp_pkg::OP_ENCODE, 8'h04, '0, '0));
    drive_item(make_item(hcbp_pkg::OP_FLUSH, 8'h00, '0, '0));

    // Random part: mostly encodes of loaded symbols, with loads, flushes and unused operations mixed in.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
      if (i == 250) begin
        hold_pending = 1'b1;
      end
      if (i == 600) begin
        drain_results();
      end
      if (!calm && $urandom_range(0, 4) == 0) begin
        sender_idle($urandom_range(1, 14));
      end
      pick = $urandom_range(0, 99);
      if ((loaded_syms.size() < 24) ? (pick < 50) : (pick < 12)) begin
        case ($urandom_range(0, 9))
          0:       len = 7'd0;
          1:       len = 7'($urandom_range(65, 127));
          2, 3, 4: len = 7'($urandom_range(13, 64));
          default: len = 7'($urandom_range(1, 12));
        endcase
        drive_item(make_item(hcbp_pkg::OP_LOAD, 8'($urandom_range(0, 255)), rand_word(),
                             len));
      end else if (pick < 90) begin
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        drive_item(make_item(hcbp_pkg::OP_ENCODE, sym, rand_word(),
                             7'($urandom_range(0, 127))));
      end else if (pick < 97) begin
        drive_item(make_item(hcbp_pkg::OP_FLUSH, 8'($urandom_range(0, 255)), rand_word(),
                             7'($urandom_range(0, 127))));
      end else begin
        drive_item(make_item(OP_UNUSED, 8'($urandom_range(0, 255)), rand_word(),
                             7'($urandom_range(0, 127))));
      end
    end

    drain_results();
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("huffman_code_bit_packer test passed");
    end else begin
      $display("huffman_code_bit_packer test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("huffman_code_bit_packer test failed");
    $finish;
  end

endmodule

// ===== huffman_code_bit_packer.f =====
+incdir+src
src/hcbp_pkg.sv
src/hcbp_code_table.sv
src/hcbp_packer.sv
src/huffman_code_bit_packer.sv
dv/hcbp_checker.sv
dv/tb.sv
